### rtl/pjfs_pkg.sv
package pjfs_pkg;

    localparam int FRAME_BITS    = 6;
    localparam int EN_BITS       = 4;
    localparam int PERIOD_BITS   = 20;
    localparam int CFG_IDX_BITS  = 3;
    localparam int OUT_TIME_BITS = 48;
    localparam int MASK_BITS     = 4;
    localparam int REL_BITS      = PERIOD_BITS + 1;

    localparam int CFG_FRAME_TICS  = 0;
    localparam int CFG_JOB_ENABLE  = 1;
    localparam int CFG_PERIOD0     = 2;
    localparam int NUM_PERIOD_REGS = 4;

    localparam logic [FRAME_BITS-1:0]  FRAME_TICS_RESET = 6'd10;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET     = 20'd1;

    typedef struct packed {
        logic load_frame;
        logic arm_step;
        logic fire;
        logic frame_end;
        logic wb_step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic found;
        logic last_slot;
    } status_t;

    // zero period runs as one
    function automatic logic [PERIOD_BITS-1:0] eff_period(input logic [PERIOD_BITS-1:0] p);
        eff_period = (p == '0) ? PERIOD_RESET : p;
    endfunction

endpackage

### rtl/pjfs_ctrl.sv
module pjfs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              frame_advance,
    output logic              in_ready,
    input  pjfs_pkg::status_t status,
    output pjfs_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ARM    = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_WB     = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd.load_frame = 1'b0;
        cmd.arm_step   = 1'b0;
        cmd.fire       = 1'b0;
        cmd.frame_end  = 1'b0;
        cmd.wb_step    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && frame_advance)
                begin
                    cmd.load_frame = 1'b1;
                    state_next     = ST_ARM;
                end
            end
            ST_ARM:
            begin
                cmd.arm_step = 1'b1;
                if (status.last_slot)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (status.out_free)
                begin
                    if (status.found)
                    begin
                        cmd.fire = 1'b1;
                    end
                    else
                    begin
                        cmd.frame_end = 1'b1;
                        state_next    = ST_WB;
                    end
                end
            end
            ST_WB:
            begin
                cmd.wb_step = 1'b1;
                if (status.last_slot)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/pjfs_dp.sv
module pjfs_dp #(
    parameter int NUM_JOBS  = 4,
    parameter int TIME_BITS = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [pjfs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [pjfs_pkg::PERIOD_BITS-1:0]     cfg_data,
    input  pjfs_pkg::cmd_t                       cmd,
    output pjfs_pkg::status_t                    status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [pjfs_pkg::OUT_TIME_BITS-1:0]   fire_time,
    output logic [pjfs_pkg::MASK_BITS-1:0]       fire_mask,
    output logic                                 frame_done
);

    localparam int IDX_BITS = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
    localparam int EXT_BITS = (TIME_BITS > pjfs_pkg::OUT_TIME_BITS) ?
                              TIME_BITS : pjfs_pkg::OUT_TIME_BITS;
    localparam int SLOT_EXT = (NUM_JOBS > pjfs_pkg::EN_BITS) ? NUM_JOBS : pjfs_pkg::EN_BITS;
    localparam logic [IDX_BITS-1:0] LAST_SLOT = IDX_BITS'(NUM_JOBS - 1);

    logic [pjfs_pkg::FRAME_BITS-1:0]  frame_tics_reg, frame_tics_next;
    logic [pjfs_pkg::EN_BITS-1:0]     job_enable_reg, job_enable_next;
    logic [pjfs_pkg::PERIOD_BITS-1:0] period_reg [NUM_JOBS];
    logic [pjfs_pkg::PERIOD_BITS-1:0] period_next [NUM_JOBS];

    logic [TIME_BITS-1:0] current_time_reg, current_time_next;
    logic [TIME_BITS-1:0] next_due_reg [NUM_JOBS];
    logic [TIME_BITS-1:0] next_due_next [NUM_JOBS];
    logic [NUM_JOBS-1:0]  armed_reg, armed_next;

    logic [TIME_BITS-1:0]            start_reg, start_next;
    logic [pjfs_pkg::FRAME_BITS-1:0] span_reg, span_next;
    logic [NUM_JOBS-1:0]             en_reg, en_next;
    logic [NUM_JOBS-1:0]             valid_reg, valid_next;
    logic [NUM_JOBS-1:0]             dirty_reg, dirty_next;
    logic [pjfs_pkg::REL_BITS-1:0]   rel_reg [NUM_JOBS];
    logic [pjfs_pkg::REL_BITS-1:0]   rel_next [NUM_JOBS];
    logic [IDX_BITS-1:0]             slot_reg, slot_next;

    logic                               out_valid_reg, out_valid_next;
    logic [pjfs_pkg::OUT_TIME_BITS-1:0] out_time_reg, out_time_next;
    logic [pjfs_pkg::MASK_BITS-1:0]     out_mask_reg, out_mask_next;
    logic                               out_done_reg, out_done_next;

    logic [pjfs_pkg::FRAME_BITS-1:0] best;
    logic                            found;
    logic [NUM_JOBS-1:0]             hit;
    logic [SLOT_EXT-1:0]             hit_ext;
    logic [SLOT_EXT-1:0]             enable_ext;
    logic [TIME_BITS-1:0]            diff;
    logic [TIME_BITS-1:0]            fire_abs;
    logic [TIME_BITS-1:0]            end_abs;
    logic [EXT_BITS-1:0]             fire_ext;
    logic [EXT_BITS-1:0]             end_ext;
    logic [pjfs_pkg::PERIOD_BITS-1:0] arm_period;
    logic [pjfs_pkg::REL_BITS-1:0]   resched [NUM_JOBS];

    // earliest in-window due slot
    always_comb
    begin
        best  = '1;
        found = 1'b0;
        for (int j = 0; j < NUM_JOBS; j++)
        begin
            if (valid_reg[j] && (!found || rel_reg[j][pjfs_pkg::FRAME_BITS-1:0] < best))
            begin
                best  = rel_reg[j][pjfs_pkg::FRAME_BITS-1:0];
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_JOBS; j++)
        begin
            hit[j]     = valid_reg[j] && (rel_reg[j][pjfs_pkg::FRAME_BITS-1:0] == best);
            resched[j] = pjfs_pkg::REL_BITS'(best)
                       + pjfs_pkg::REL_BITS'(pjfs_pkg::eff_period(period_reg[j]));
        end
    end

    assign hit_ext    = SLOT_EXT'(hit);
    assign enable_ext = SLOT_EXT'(job_enable_reg);
    assign diff       = next_due_reg[slot_reg] - start_reg;
    assign arm_period = pjfs_pkg::eff_period(period_reg[slot_reg]);
    assign fire_abs   = start_reg + TIME_BITS'(best);
    assign end_abs    = start_reg + TIME_BITS'(span_reg);
    assign fire_ext   = EXT_BITS'(fire_abs);
    assign end_ext    = EXT_BITS'(end_abs);

    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.found     = found;
    assign status.last_slot = (slot_reg == LAST_SLOT);

    always_comb
    begin
        frame_tics_next   = frame_tics_reg;
        job_enable_next   = job_enable_reg;
        period_next       = period_reg;
        current_time_next = current_time_reg;
        next_due_next     = next_due_reg;
        armed_next        = armed_reg;
        start_next        = start_reg;
        span_next         = span_reg;
        en_next           = en_reg;
        valid_next        = valid_reg;
        dirty_next        = dirty_reg;
        rel_next          = rel_reg;
        slot_next         = slot_reg;
        out_time_next     = out_time_reg;
        out_mask_next     = out_mask_reg;
        out_done_next     = out_done_reg;
        out_valid_next    = out_ready ? 1'b0 : out_valid_reg;

        if (cfg_valid)
        begin
            if (int'(cfg_index) == pjfs_pkg::CFG_FRAME_TICS)
            begin
                frame_tics_next = cfg_data[pjfs_pkg::FRAME_BITS-1:0];
            end
            if (int'(cfg_index) == pjfs_pkg::CFG_JOB_ENABLE)
            begin
                job_enable_next = cfg_data[pjfs_pkg::EN_BITS-1:0];
            end
            for (int j = 0; j < NUM_JOBS; j++)
            begin
                if (j < pjfs_pkg::NUM_PERIOD_REGS && int'(cfg_index) == pjfs_pkg::CFG_PERIOD0 + j)
                begin
                    period_next[j] = cfg_data;
                end
            end
        end

        if (cmd.load_frame)
        begin
            start_next = current_time_reg;
            span_next  = frame_tics_reg;
            en_next    = enable_ext[NUM_JOBS-1:0];
            slot_next  = '0;
        end

        if (cmd.arm_step || cmd.wb_step)
        begin
            slot_next = status.last_slot ? '0 : slot_reg + 1'b1;
        end

        if (cmd.arm_step)
        begin
            if (en_reg[slot_reg])
            begin
                if (!armed_reg[slot_reg])
                begin
                    // freshly armed: due one period after frame start
                    armed_next[slot_reg] = 1'b1;
                    dirty_next[slot_reg] = 1'b1;
                    rel_next[slot_reg]   = pjfs_pkg::REL_BITS'(arm_period);
                    valid_next[slot_reg] = arm_period <= pjfs_pkg::PERIOD_BITS'(span_reg);
                end
                else
                begin
                    dirty_next[slot_reg] = 1'b0;
                    rel_next[slot_reg]   = diff[pjfs_pkg::REL_BITS-1:0];
                    valid_next[slot_reg] = (diff != '0) && (diff <= TIME_BITS'(span_reg));
                end
            end
            else
            begin
                armed_next[slot_reg] = 1'b0;
                valid_next[slot_reg] = 1'b0;
                dirty_next[slot_reg] = 1'b0;
            end
        end

        if (cmd.fire)
        begin
            for (int j = 0; j < NUM_JOBS; j++)
            begin
                if (hit[j])
                begin
                    rel_next[j]   = resched[j];
                    valid_next[j] = resched[j] <= pjfs_pkg::REL_BITS'(span_reg);
                    dirty_next[j] = 1'b1;
                end
            end
            out_valid_next = 1'b1;
            out_time_next  = fire_ext[pjfs_pkg::OUT_TIME_BITS-1:0];
            out_mask_next  = hit_ext[pjfs_pkg::MASK_BITS-1:0];
            out_done_next  = 1'b0;
        end

        if (cmd.frame_end)
        begin
            current_time_next = end_abs;
            slot_next         = '0;
            out_valid_next    = 1'b1;
            out_time_next     = end_ext[pjfs_pkg::OUT_TIME_BITS-1:0];
            out_mask_next     = '0;
            out_done_next     = 1'b1;
        end

        // commit rescheduled due times, relative to frame start
        if (cmd.wb_step && dirty_reg[slot_reg])
        begin
            next_due_next[slot_reg] = start_reg + TIME_BITS'(rel_reg[slot_reg]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_tics_reg   <= pjfs_pkg::FRAME_TICS_RESET;
            job_enable_reg   <= '0;
            current_time_reg <= '0;
            armed_reg        <= '0;
            en_reg           <= '0;
            valid_reg        <= '0;
            dirty_reg        <= '0;
            slot_reg         <= '0;
            out_valid_reg    <= 1'b0;
            for (int j = 0; j < NUM_JOBS; j++)
            begin
                period_reg[j]   <= pjfs_pkg::PERIOD_RESET;
                next_due_reg[j] <= '0;
            end
        end
        else
        begin
            frame_tics_reg   <= frame_tics_next;
            job_enable_reg   <= job_enable_next;
            current_time_reg <= current_time_next;
            armed_reg        <= armed_next;
            en_reg           <= en_next;
            valid_reg        <= valid_next;
            dirty_reg        <= dirty_next;
            slot_reg         <= slot_next;
            out_valid_reg    <= out_valid_next;
            period_reg       <= period_next;
            next_due_reg     <= next_due_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        span_reg     <= span_next;
        rel_reg      <= rel_next;
        out_time_reg <= out_time_next;
        out_mask_reg <= out_mask_next;
        out_done_reg <= out_done_next;
    end

    assign out_valid  = out_valid_reg;
    assign fire_time  = out_time_reg;
    assign fire_mask  = out_mask_reg;
    assign frame_done = out_done_reg;

endmodule

### rtl/periodic_job_frame_scheduler_unit.sv
// A frame accept is followed by a slot arming pass over all job slots before the first result.
// Each result then comes from one compare over all job slots, held while the output stalls, frame end last;
// a final pass over all job slots writes back due times before the next frame is taken.
// A frame gives F results for its firing times (F <= 63), then the frame end result.
// A frame_advance of 0 is taken while idle and gives no result.
// Reset: asynchronous active low; time, due times and arming cleared, registers to defaults.
module periodic_job_frame_scheduler_unit #(
    parameter int NUM_JOBS  = 4,
    parameter int TIME_BITS = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pjfs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [pjfs_pkg::PERIOD_BITS-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 frame_advance,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [pjfs_pkg::OUT_TIME_BITS-1:0]   fire_time,
    output logic [pjfs_pkg::MASK_BITS-1:0]       fire_mask,
    output logic                                 frame_done
);

    pjfs_pkg::cmd_t    cmd;
    pjfs_pkg::status_t status;

    assign cfg_ready = 1'b1;

    pjfs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .frame_advance (frame_advance),
        .in_ready      (in_ready),
        .status        (status),
        .cmd           (cmd)
    );

    pjfs_dp #(
        .NUM_JOBS  (NUM_JOBS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .fire_time  (fire_time),
        .fire_mask  (fire_mask),
        .frame_done (frame_done)
    );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int NUM_JOBS         = 4;
    localparam int TIME_BITS        = 48;
    localparam int IDLE_PCT         = 14;
    localparam int SETTLE_CYCLES    = 2 * NUM_JOBS + 8;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int NUM_PHASES       = 10;
    localparam int FRAMES_PER_PHASE = 21;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int MAX_REPORTS      = 200;
    localparam int NO_CHECK         = -1;
    localparam int CFG_UNUSED       = pjfs_pkg::CFG_PERIOD0 + pjfs_pkg::NUM_PERIOD_REGS;
    localparam int NUM_ROWS         = 25;

    typedef struct packed {
        logic [pjfs_pkg::OUT_TIME_BITS-1:0] tic;
        logic [pjfs_pkg::MASK_BITS-1:0]     mask;
        logic                               done;
    } fire_rec_t;

    typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        int                               idx;
        logic [pjfs_pkg::PERIOD_BITS-1:0] data;
        logic                             adv;
        int                               n_typed;
        fire_rec_t                        typed;
    } stim_row_t;

    localparam fire_rec_t NO_FIRE      = '0;
    localparam fire_rec_t MARKER_AT_10 = '{48'd10, 4'h0, 1'b1};

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [pjfs_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [pjfs_pkg::PERIOD_BITS-1:0]   cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic                               frame_advance = 1'b0;
    logic                               out_valid;
    logic                               out_ready;
    logic [pjfs_pkg::OUT_TIME_BITS-1:0] fire_time;
    logic [pjfs_pkg::MASK_BITS-1:0]     fire_mask;
    logic                               frame_done;

    // scheduler state as predicted
    logic [TIME_BITS-1:0]             now_tic;
    logic [TIME_BITS-1:0]             due_tic [NUM_JOBS];
    logic                             slot_armed [NUM_JOBS];
    logic [pjfs_pkg::FRAME_BITS-1:0]  frame_len;
    logic [pjfs_pkg::EN_BITS-1:0]     slot_en;
    logic [pjfs_pkg::PERIOD_BITS-1:0] slot_period [NUM_JOBS];

    fire_rec_t fire_queue [$];
    fire_rec_t frame_fires [$];

    int  errors;
    int  cycle_count;
    int  hold_cycles;
    bit  calm;
    int  frames_sent;
    int  advances_sent;
    int  writes_done;
    int  results_seen;
    int  firings_seen;
    int  busiest_frame;

    stim_row_t plan [NUM_ROWS] = '{
        '{ROW_FRAME, 0, 20'h0, 1'b1, 1, MARKER_AT_10},
        '{ROW_FRAME, 0, 20'h0, 1'b0, 0, NO_FIRE},
        '{ROW_WRITE, pjfs_pkg::CFG_FRAME_TICS, 20'h0, 1'b0, 0, NO_FIRE},
        '{ROW_FRAME, 0, 20'h0, 1'b1, 1, MARKER_AT_10},
        '{ROW_WRITE, pjfs_pkg::CFG_JOB_ENABLE, 20'hFFFFF, 1'b0, 0, NO_FIRE},
        '{ROW_FRAME, 0, 20'h0, 1'b1, 1, MARKER_AT_10},
        '{ROW_WRITE, pjfs_pkg::CFG_FRAME_TICS, 20'hFFFFF, 1'b0, 0, NO_FIRE},
        '{ROW_FRAME, 0, 20'h0, 1'b1, NO_CHECK, NO_FIRE},
        '{ROW_WRITE, pjfs_pkg::CFG_PERIOD0, 20'h0, 1'b0, 0, NO_FIRE},
        '{ROW_WRITE, pjfs_pkg::CFG_PERIOD0 + 1, 20'hFFFFF, 1'b0, 0, NO_FIRE},
        '{ROW_WRITE, pjfs_pkg::CFG_PERIOD0 + 2, 20'h3, 1'b0, 0, NO_FIRE},
        '{ROW_WRITE, pjfs_pkg::CFG_PERIOD0 + 3, 20'h7, 1'b0, 0, NO_FIRE},
        '{ROW_FRAME, 0, 20'h0, 1'b1, NO_CHECK, NO_FIRE},
        '{ROW_FRAME, 0, 20'h0, 1'b1, NO_CHECK, NO_FIRE},
        '{ROW_WRITE, CFG_UNUSED, 20'h5, 1'b0, 0, NO_FIRE},
        '{ROW_WRITE, CFG_UNUSED + 1, 20'hFFFFF, 1'b0, 0, NO_FIRE},
        '{ROW_FRAME, 0, 20'h0, 1'b1, NO_CHECK, NO_FIRE},
        '{ROW_WRITE, pjfs_pkg::CFG_JOB_ENABLE, 20'h5, 1'b0, 0, NO_FIRE},
        '{ROW_FRAME, 0, 20'h0, 1'b1, NO_CHECK, NO_FIRE},
        '{ROW_WRITE, pjfs_pkg::CFG_JOB_ENABLE, 20'hA, 1'b0, 0, NO_FIRE},
        '{ROW_FRAME, 0, 20'h0, 1'b1, NO_CHECK, NO_FIRE},
        '{ROW_WRITE, pjfs_pkg::CFG_FRAME_TICS, 20'h1, 1'b0, 0, NO_FIRE},
        '{ROW_FRAME, 0, 20'h0, 1'b1, NO_CHECK, NO_FIRE},
        '{ROW_FRAME, 0, 20'h0, 1'b0, 0, NO_FIRE},
        '{ROW_FRAME, 0, 20'h0, 1'b1, NO_CHECK, NO_FIRE}
    };

    periodic_job_frame_scheduler_unit #(
        .NUM_JOBS  (NUM_JOBS),
        .TIME_BITS (TIME_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .frame_advance (frame_advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fire_time     (fire_time),
        .fire_mask     (fire_mask),
        .frame_done    (frame_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [pjfs_pkg::PERIOD_BITS-1:0] tic_period(input int j);
        return (slot_period[j] == '0) ? pjfs_pkg::PERIOD_BITS'(1) : slot_period[j];
    endfunction

    function automatic void reset_model();
        now_tic   = '0;
        frame_len = pjfs_pkg::FRAME_TICS_RESET;
        slot_en   = '0;
        for (int j = 0; j < NUM_JOBS; j++)
        begin
            due_tic[j]     = '0;
            slot_armed[j]  = 1'b0;
            slot_period[j] = pjfs_pkg::PERIOD_RESET;
        end
    endfunction

    function automatic void apply_reg_write(input int idx,
                                            input logic [pjfs_pkg::PERIOD_BITS-1:0] data);
        if (idx == pjfs_pkg::CFG_FRAME_TICS)
            frame_len = data[pjfs_pkg::FRAME_BITS-1:0];
        else if (idx == pjfs_pkg::CFG_JOB_ENABLE)
            slot_en = data[pjfs_pkg::EN_BITS-1:0];
        else if (idx >= pjfs_pkg::CFG_PERIOD0 &&
                 idx < pjfs_pkg::CFG_PERIOD0 + pjfs_pkg::NUM_PERIOD_REGS)
            slot_period[idx - pjfs_pkg::CFG_PERIOD0] = data;
    endfunction

    // fills frame_fires with the results of one frame item
    function automatic void advance_frame_model(input logic adv);
        logic [TIME_BITS-1:0]            start;
        logic [TIME_BITS-1:0]            pos;
        logic [TIME_BITS-1:0]            best;
        logic [TIME_BITS-1:0]            delta;
        logic [pjfs_pkg::FRAME_BITS-1:0] span;
        logic [pjfs_pkg::MASK_BITS-1:0]  hit;
        frame_fires.delete();
        if (!adv)
            return;
        start = now_tic;
        span  = frame_len;
        for (int j = 0; j < NUM_JOBS; j++)
        begin
            if (slot_en[j])
            begin
                if (!slot_armed[j])
                begin
                    due_tic[j]    = start + tic_period(j);
                    slot_armed[j] = 1'b1;
                end
            end
            else
                slot_armed[j] = 1'b0;
        end
        pos = '0;
        forever
        begin
            best = TIME_BITS'(span) + 1;
            for (int j = 0; j < NUM_JOBS; j++)
            begin
                if (slot_armed[j])
                begin
                    delta = due_tic[j] - start;
                    if (delta > pos && delta <= span && delta < best)
                        best = delta;
                end
            end
            if (best > span)
                break;
            hit = '0;
            for (int j = 0; j < NUM_JOBS; j++)
            begin
                delta = due_tic[j] - start;
                if (slot_armed[j] && delta == best)
                begin
                    hit[j]     = 1'b1;
                    due_tic[j] = start + best + tic_period(j);
                end
            end
            pos = best;
            frame_fires.push_back('{start + best, hit, 1'b0});
        end
        now_tic = start + span;
        frame_fires.push_back('{now_tic, 4'h0, 1'b1});
    endfunction

    task automatic cfg_write(input int idx, input logic [pjfs_pkg::PERIOD_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= pjfs_pkg::CFG_IDX_BITS'(idx);
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg_write(idx, data);
        writes_done++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input logic adv, input int n_typed, input fire_rec_t typed);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        frame_advance <= adv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_frame_model(adv);
        frames_sent++;
        if (adv)
            advances_sent++;
        if (frame_fires.size() > busiest_frame)
            busiest_frame = frame_fires.size();
        if (n_typed == NO_CHECK)
        begin
            foreach (frame_fires[k])
                fire_queue.push_back(frame_fires[k]);
        end
        else if (n_typed == 1)
            fire_queue.push_back(typed);
    endtask

    // block must be idle before a register write
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (fire_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic randomize_setup();
        logic [pjfs_pkg::PERIOD_BITS-1:0] word;
        word = pjfs_pkg::PERIOD_BITS'($urandom);
        case ($urandom_range(0, 7))
            0:       word[pjfs_pkg::FRAME_BITS-1:0] = '0;
            1:       word[pjfs_pkg::FRAME_BITS-1:0] = pjfs_pkg::FRAME_BITS'(1);
            2:       word[pjfs_pkg::FRAME_BITS-1:0] = '1;
            default: word[pjfs_pkg::FRAME_BITS-1:0] =
                         pjfs_pkg::FRAME_BITS'($urandom_range(4, 40));
        endcase
        cfg_write(pjfs_pkg::CFG_FRAME_TICS, word);
        cfg_write(pjfs_pkg::CFG_JOB_ENABLE, pjfs_pkg::PERIOD_BITS'($urandom));
        for (int s = 0; s < pjfs_pkg::NUM_PERIOD_REGS; s++)
        begin
            case ($urandom_range(0, 9))
                0:       word = '0;
                1:       word = '1;
                2:       word = pjfs_pkg::PERIOD_BITS'($urandom);
                default: word = pjfs_pkg::PERIOD_BITS'($urandom_range(1, 24));
            endcase
            cfg_write(pjfs_pkg::CFG_PERIOD0 + s, word);
        end
        if ($urandom_range(0, 2) == 0)
            cfg_write(CFG_UNUSED + $urandom_range(0, 1), pjfs_pkg::PERIOD_BITS'($urandom));
    endtask

    initial
    begin : receiver
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : check_results
        fire_rec_t got;
        fire_rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{fire_time, fire_mask, frame_done};
            results_seen++;
            if (!frame_done)
                firings_seen++;
            if (fire_queue.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with none expected: tic %0d mask %h done %b",
                             $time, got.tic, got.mask, got.done);
            end
            else
            begin
                want = fire_queue.pop_front();
                if (got.tic !== want.tic)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: fire_time expected %0d actual %0d",
                                 $time, want.tic, got.tic);
                end
                if (got.mask !== want.mask)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: fire_mask expected %h actual %h",
                                 $time, want.mask, got.mask);
                end
                if (got.done !== want.done)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: frame_done expected %b actual %b",
                                 $time, want.done, got.done);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, fire_queue.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        bit   last_was_frame;
        int   adv_count;
        logic adv;
        errors         = 0;
        cycle_count    = 0;
        hold_cycles    = 0;
        calm           = 1'b0;
        frames_sent    = 0;
        advances_sent  = 0;
        writes_done    = 0;
        results_seen   = 0;
        firings_seen   = 0;
        busiest_frame  = 0;
        last_was_frame = 1'b0;
        reset_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                if (last_was_frame)
                    settle();
                cfg_write(plan[i].idx, plan[i].data);
                last_was_frame = 1'b0;
            end
            else
            begin
                send_frame(plan[i].adv, plan[i].n_typed, plan[i].typed);
                last_was_frame = 1'b1;
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            randomize_setup();
            calm = (phase == 5 || phase == 6);
            // long receiver stall so the block backs up into its input
            if (phase == 2)
                hold_cycles = HOLD_OFF_CYCLES;
            adv_count = 0;
            while (adv_count < FRAMES_PER_PHASE)
            begin
                adv = ($urandom_range(0, 9) != 0);
                send_frame(adv, NO_CHECK, NO_FIRE);
                if (adv)
                    adv_count++;
            end
        end
        calm = 1'b0;
        settle();

        $display("Covered %0d frame items (%0d advancing) and %0d register writes.",
                 frames_sent, advances_sent, writes_done);
        $display("Checked %0d results, %0d job firings, up to %0d results in one frame.",
                 results_seen, firings_seen, busiest_frame);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
rtl/pjfs_pkg.sv
rtl/pjfs_ctrl.sv
rtl/pjfs_dp.sv
rtl/periodic_job_frame_scheduler_unit.sv
test/tb_top.sv
